FILE: src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int CFG_WIDTH     = 10;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int BITS_PER_BYTE = 8;
   localparam int READ_LOW_US   = 3;
   localparam int READ_TAIL_US  = 40;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RESET_LOW   = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_PRES_WAIT   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RESET_TAIL  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_W1_LOW      = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_W1_HIGH     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_W0_LOW      = 3'd5;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_W0_HIGH     = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RD_SAMPLE   = 3'd7;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_RD_LOW   = 4'd6,
      PH_RD_WAIT  = 4'd7,
      PH_RD_TAIL  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] write_byte;
      logic       line_level;
   } req_word_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_byte;
      logic       rejected;
   } rsp_word_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] reset_low_us;
      logic [CFG_WIDTH-1:0] presence_wait_us;
      logic [CFG_WIDTH-1:0] reset_tail_us;
      logic [CFG_WIDTH-1:0] write_one_low_us;
      logic [CFG_WIDTH-1:0] write_one_high_us;
      logic [CFG_WIDTH-1:0] write_zero_low_us;
      logic [CFG_WIDTH-1:0] write_zero_high_us;
      logic [CFG_WIDTH-1:0] read_sample_us;
   } cfg_type;

   localparam cfg_type CFG_DEFAULTS = '{
      reset_low_us:       10'd600,
      presence_wait_us:   10'd30,
      reset_tail_us:      10'd500,
      write_one_low_us:   10'd6,
      write_one_high_us:  10'd74,
      write_zero_low_us:  10'd65,
      write_zero_high_us: 10'd20,
      read_sample_us:     10'd30
   };

endpackage

FILE: src/owbm_csr.sv
// ----------------------------------------------------------------------------
// owbm_csr
// Timing register file, write only.
// ----------------------------------------------------------------------------
module owbm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [owbm_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [owbm_pkg::CFG_WIDTH-1:0]      csr_data,
   output owbm_pkg::cfg_type                   cfg
);

   owbm_pkg::cfg_type cfg_ff;
   owbm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            owbm_pkg::CSR_RESET_LOW:  cfg_in.reset_low_us       = csr_data;
            owbm_pkg::CSR_PRES_WAIT:  cfg_in.presence_wait_us   = csr_data;
            owbm_pkg::CSR_RESET_TAIL: cfg_in.reset_tail_us      = csr_data;
            owbm_pkg::CSR_W1_LOW:     cfg_in.write_one_low_us   = csr_data;
            owbm_pkg::CSR_W1_HIGH:    cfg_in.write_one_high_us  = csr_data;
            owbm_pkg::CSR_W0_LOW:     cfg_in.write_zero_low_us  = csr_data;
            owbm_pkg::CSR_W0_HIGH:    cfg_in.write_zero_high_us = csr_data;
            owbm_pkg::CSR_RD_SAMPLE:  cfg_in.read_sample_us     = csr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= owbm_pkg::CFG_DEFAULTS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/owbm_seq.sv
// ----------------------------------------------------------------------------
// owbm_seq
// Bus sequencer: phase state, slot timer and byte shifter, one word per step.
// ----------------------------------------------------------------------------
module owbm_seq #(
   parameter int TIMER_WIDTH = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  owbm_pkg::req_word_type item,
   input  owbm_pkg::cfg_type      cfg,
   output owbm_pkg::rsp_word_type result
);

   owbm_pkg::phase_type    phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] time_left_ff, time_left_in;
   logic [2:0]             bit_index_ff, bit_index_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic                   presence_ff, presence_in;
   logic [1:0]             kind_ff, kind_in;
   logic [7:0]             read_result_ff, read_result_in;

   logic start;
   logic active;

   // zero load counts as one tick
   function automatic logic [TIMER_WIDTH-1:0] load_ticks(input logic [TIMER_WIDTH-1:0] t);
      return (t == '0) ? TIMER_WIDTH'(1) : t;
   endfunction

   assign start  = (item.operation != owbm_pkg::OP_TICK) && (phase_ff == owbm_pkg::PH_IDLE);
   assign active = (phase_ff != owbm_pkg::PH_IDLE) || start;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      time_left_in   = time_left_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      presence_in    = presence_ff;
      kind_in        = kind_ff;
      read_result_in = read_result_ff;

      if (start) begin
         kind_in      = item.operation;
         bit_index_in = '0;
         case (item.operation)
            owbm_pkg::OP_RESET: begin
               phase_in     = owbm_pkg::PH_RST_LOW;
               time_left_in = load_ticks(TIMER_WIDTH'(cfg.reset_low_us));
            end
            owbm_pkg::OP_WRITE: begin
               shift_byte_in = item.write_byte;
               phase_in      = owbm_pkg::PH_WR_LOW;
               time_left_in  = load_ticks(item.write_byte[0]
                                  ? TIMER_WIDTH'(cfg.write_one_low_us)
                                  : TIMER_WIDTH'(cfg.write_zero_low_us));
            end
            owbm_pkg::OP_READ: begin
               shift_byte_in = '0;
               phase_in      = owbm_pkg::PH_RD_LOW;
               time_left_in  = load_ticks(TIMER_WIDTH'(owbm_pkg::READ_LOW_US));
            end
            default: ;
         endcase
      end

      if (phase_in != owbm_pkg::PH_IDLE) begin
         time_left_in = time_left_in - TIMER_WIDTH'(1);
         if (time_left_in == '0) begin
            unique case (phase_in)
               owbm_pkg::PH_RST_LOW: begin
                  phase_in     = owbm_pkg::PH_RST_WAIT;
                  time_left_in = load_ticks(TIMER_WIDTH'(cfg.presence_wait_us));
               end
               owbm_pkg::PH_RST_WAIT: begin
                  presence_in  = ~item.line_level;
                  phase_in     = owbm_pkg::PH_RST_TAIL;
                  time_left_in = load_ticks(TIMER_WIDTH'(cfg.reset_tail_us));
               end
               owbm_pkg::PH_RST_TAIL: begin
                  phase_in = owbm_pkg::PH_IDLE;
               end
               owbm_pkg::PH_WR_LOW: begin
                  phase_in     = owbm_pkg::PH_WR_HIGH;
                  time_left_in = load_ticks(shift_byte_in[bit_index_in]
                                    ? TIMER_WIDTH'(cfg.write_one_high_us)
                                    : TIMER_WIDTH'(cfg.write_zero_high_us));
               end
               owbm_pkg::PH_WR_HIGH: begin
                  if (bit_index_in == 3'(owbm_pkg::BITS_PER_BYTE - 1)) begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end else begin
                     bit_index_in = bit_index_in + 3'd1;
                     phase_in     = owbm_pkg::PH_WR_LOW;
                     time_left_in = load_ticks(shift_byte_in[bit_index_in]
                                       ? TIMER_WIDTH'(cfg.write_one_low_us)
                                       : TIMER_WIDTH'(cfg.write_zero_low_us));
                  end
               end
               owbm_pkg::PH_RD_LOW: begin
                  phase_in     = owbm_pkg::PH_RD_WAIT;
                  time_left_in = load_ticks(TIMER_WIDTH'(cfg.read_sample_us));
               end
               owbm_pkg::PH_RD_WAIT: begin
                  if (item.line_level) begin
                     shift_byte_in[bit_index_in] = 1'b1;
                  end
                  phase_in     = owbm_pkg::PH_RD_TAIL;
                  time_left_in = load_ticks(TIMER_WIDTH'(owbm_pkg::READ_TAIL_US));
               end
               owbm_pkg::PH_RD_TAIL: begin
                  if (bit_index_in == 3'(owbm_pkg::BITS_PER_BYTE - 1)) begin
                     read_result_in = shift_byte_in;
                     phase_in       = owbm_pkg::PH_IDLE;
                  end else begin
                     bit_index_in = bit_index_in + 3'd1;
                     phase_in     = owbm_pkg::PH_RD_LOW;
                     time_left_in = load_ticks(TIMER_WIDTH'(owbm_pkg::READ_LOW_US));
                  end
               end
               default: phase_in = owbm_pkg::PH_IDLE;
            endcase
         end
      end
   end

   // outputs; every command opens with a low phase
   always_comb begin
      result.drive_low = start
                         || (phase_ff == owbm_pkg::PH_RST_LOW)
                         || (phase_ff == owbm_pkg::PH_WR_LOW)
                         || (phase_ff == owbm_pkg::PH_RD_LOW);
      result.busy_res  = (phase_in != owbm_pkg::PH_IDLE);
      result.done_res  = active && (phase_in == owbm_pkg::PH_IDLE);
      result.presence  = presence_in;
      result.read_byte = read_result_in;
      result.rejected  = (item.operation != owbm_pkg::OP_TICK)
                         && (phase_ff != owbm_pkg::PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= owbm_pkg::PH_IDLE;
         time_left_ff   <= '0;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         presence_ff    <= 1'b0;
         kind_ff        <= owbm_pkg::OP_TICK;
         read_result_ff <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         time_left_ff   <= time_left_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         presence_ff    <= presence_in;
         kind_ff        <= kind_in;
         read_result_ff <= read_result_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_idle_tick_stays_idle: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == owbm_pkg::PH_IDLE) && (item.operation == owbm_pkg::OP_TICK)
      |=> phase_ff == owbm_pkg::PH_IDLE)
      else $error("idle tick left idle");
   a_busy_has_kind: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != owbm_pkg::PH_IDLE) |-> (kind_ff != owbm_pkg::OP_TICK))
      else $error("command running with no kind");
   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      result.rejected |-> (phase_ff != owbm_pkg::PH_IDLE) && !start)
      else $error("reject while idle");
`endif

endmodule

FILE: src/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master timed by one-microsecond tick words.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Word
// req_     in         req_valid / req_stall  operation, write_byte, line_level
// rsp_     out        rsp_valid / rsp_stall  drive_low .. rejected
// csr_     in         csr_write_en           csr_index, csr_data (10 bit)
//
// One word accepted per cycle while rsp_stall does not hold the pipe; a result
// word follows via the input register, then the sequencer and result register.
// The sequencer steps once per word as it moves into the result register.
// Reset is synchronous: sequencer idle, timing registers at their defaults.
// A stalled result holds; req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
   parameter int TIMER_WIDTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  owbm_pkg::req_word_type              req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output owbm_pkg::rsp_word_type              rsp_word,
   input  logic                                csr_write_en,
   input  logic [owbm_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [owbm_pkg::CFG_WIDTH-1:0]      csr_data
);

   owbm_pkg::cfg_type      cfg;
   owbm_pkg::rsp_word_type seq_result;

   // input stage
   logic                   in_valid_ff, in_valid_in;
   owbm_pkg::req_word_type in_word_ff;
   // result stage
   logic                   out_valid_ff, out_valid_in;
   owbm_pkg::rsp_word_type out_word_ff;

   logic out_free;   // result register can take a word this cycle
   logic advance;    // input word steps the sequencer and moves on
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   owbm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   owbm_seq #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_word_ff),
      .cfg    (cfg),
      .result (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= seq_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

`ifndef NO_ASSERTIONS
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("stepped word lost");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_word_ff.done_res |-> !out_word_ff.busy_res)
      else $error("done and busy together");
   a_no_step_when_blocked: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |-> !advance)
      else $error("sequencer stepped into full result stage");
`endif

endmodule

FILE: sim/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Self-checking bench for the 1-Wire bus master. A scripted opening at short
// fixed timings runs reset, write and read commands. Random phases follow at
// zero, small, unit, mixed and full-scale timings; the registers are rewritten
// whenever the pipe has run dry, with or without a command still running.
// Every word is checked field by field against a scripted expected word or one
// predicted by a cycle model of the bus sequencer.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;

   localparam int NUM_TIMINGS    = 8;
   localparam int SCRIPT_TIMING  = 4;     // reset low outlasts the three rejected commands
   localparam int PHASE_WORDS    = 40;    // random words per timing phase
   localparam int LONG_HOLD      = 300;   // receiver hold-off, long enough to fill the block
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int END_CYCLES     = 8;     // two-stage pipe plus margin

   // timing phases: register range, sender gap and receiver stall limits
   // phase 6 puts every register at full scale
   localparam int NUM_PHASES = 8;
   localparam int HOLD_PHASE = 2;
   localparam int TIMING_LO  [NUM_PHASES] = '{0,  1, 1,  1,  0,  1,  1023, 1};
   localparam int TIMING_HI  [NUM_PHASES] = '{0,  8, 8,  1,  40, 8,  1023, 12};
   localparam int SEND_GAP   [NUM_PHASES] = '{16, 0, 0,  16, 16, 0,  0,    16};
   localparam int RECV_GAP   [NUM_PHASES] = '{16, 0, 16, 16, 0,  16, 0,    16};

   typedef logic [owbm_pkg::CFG_WIDTH-1:0]     timing_type;
   typedef logic [owbm_pkg::CSR_IDX_WIDTH-1:0] csr_index_type;

   // how the bus line answers while a scripted command is ticked to its end
   typedef enum logic [1:0] {LINE_NONE, LINE_LOW, LINE_HIGH, LINE_RANDOM} line_plan_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [7:0]             write_byte;
      logic                   line_level;
      line_plan_type          tail_line;
      logic                   fixed;      // want holds the expected word
      owbm_pkg::rsp_word_type want;
   } script_row_type;

   // expected words readable straight off the spec
   // field order: drive_low, busy_res, done_res, presence, read_byte, rejected
   localparam owbm_pkg::rsp_word_type QUIET          = '0;
   localparam owbm_pkg::rsp_word_type RST_START      = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
   localparam owbm_pkg::rsp_word_type BUSY_REJ       = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};
   localparam owbm_pkg::rsp_word_type IDLE_PRES      = '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0};
   localparam owbm_pkg::rsp_word_type IDLE_FF        = '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0};
   localparam owbm_pkg::rsp_word_type IDLE_ABSENT_FF = '{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0};

   localparam int SCRIPT_ROWS = 15;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // idle after reset
      '{owbm_pkg::OP_TICK,  8'h00, 1'b1, LINE_NONE,   1'b1, QUIET},
      '{owbm_pkg::OP_TICK,  8'hFF, 1'b0, LINE_NONE,   1'b1, QUIET},
      // first reset microsecond, commands while busy, then the device answers
      '{owbm_pkg::OP_RESET, 8'h00, 1'b1, LINE_NONE,   1'b1, RST_START},
      '{owbm_pkg::OP_WRITE, 8'h3C, 1'b1, LINE_NONE,   1'b1, BUSY_REJ},
      '{owbm_pkg::OP_READ,  8'h00, 1'b0, LINE_NONE,   1'b1, BUSY_REJ},
      '{owbm_pkg::OP_RESET, 8'hFF, 1'b1, LINE_LOW,    1'b1, BUSY_REJ},
      '{owbm_pkg::OP_TICK,  8'h00, 1'b1, LINE_NONE,   1'b1, IDLE_PRES},
      // all ones, then all zeros; the script timings make both lows equal
      '{owbm_pkg::OP_WRITE, 8'hFF, 1'b0, LINE_RANDOM, 1'b0, QUIET},
      '{owbm_pkg::OP_WRITE, 8'h00, 1'b1, LINE_RANDOM, 1'b0, QUIET},
      '{owbm_pkg::OP_READ,  8'h00, 1'b1, LINE_HIGH,   1'b0, QUIET},
      '{owbm_pkg::OP_TICK,  8'h00, 1'b0, LINE_NONE,   1'b1, IDLE_FF},
      // nobody answers
      '{owbm_pkg::OP_RESET, 8'h00, 1'b0, LINE_HIGH,   1'b0, QUIET},
      '{owbm_pkg::OP_TICK,  8'h00, 1'b0, LINE_NONE,   1'b1, IDLE_ABSENT_FF},
      // a reset on the word straight after the write's done word
      '{owbm_pkg::OP_WRITE, 8'hA5, 1'b0, LINE_RANDOM, 1'b0, QUIET},
      '{owbm_pkg::OP_RESET, 8'h5A, 1'b1, LINE_RANDOM, 1'b0, QUIET}
   };

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_stall;
   owbm_pkg::req_word_type req_word     = '0;
   logic                   rsp_valid;
   logic                   rsp_stall    = 1'b0;
   owbm_pkg::rsp_word_type rsp_word;
   logic                   csr_write_en = 1'b0;
   csr_index_type          csr_index    = '0;
   timing_type             csr_data     = '0;

   // sequencer model state
   timing_type           timing [NUM_TIMINGS];
   owbm_pkg::phase_type  bus_phase;
   timing_type           slot_timer;
   logic [2:0]           bit_pos;
   logic [7:0]           shifter;
   logic                 presence_flag;
   logic [7:0]           last_read;

   owbm_pkg::rsp_word_type awaited_responses [$];
   int                     failures        = 0;
   int                     idle_cycles     = 0;
   int                     send_gap_max    = 16;
   int                     recv_gap_max    = 16;
   logic                   long_hold_armed = 1'b0;

   one_wire_bus_master i_dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_word,
      .rsp_valid,
      .rsp_stall,
      .rsp_word,
      .csr_write_en,
      .csr_index,
      .csr_data
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ------------------------------------------------------------------------
   // Sequencer model: one call per accepted word, i.e. one bus microsecond.
   // ------------------------------------------------------------------------
   function automatic void load_phase(input owbm_pkg::phase_type next,
                                      input timing_type ticks);
      bus_phase  = next;
      slot_timer = (ticks == '0) ? timing_type'(1) : ticks;   // zero counts as one tick
   endfunction

   function automatic void load_write_low();
      load_phase(owbm_pkg::PH_WR_LOW, shifter[bit_pos] ? timing[owbm_pkg::CSR_W1_LOW]
                                                       : timing[owbm_pkg::CSR_W0_LOW]);
   endfunction

   function automatic owbm_pkg::rsp_word_type bus_microsecond(
         input owbm_pkg::req_word_type w);
      owbm_pkg::rsp_word_type r;
      logic                   last_bit;
      r = '0;
      // a command only starts from idle; otherwise flagged and treated as a tick
      if (w.operation != owbm_pkg::OP_TICK) begin
         if (bus_phase != owbm_pkg::PH_IDLE) begin
            r.rejected = 1'b1;
         end else begin
            bit_pos = '0;
            case (w.operation)
               owbm_pkg::OP_RESET: load_phase(owbm_pkg::PH_RST_LOW,
                                              timing[owbm_pkg::CSR_RESET_LOW]);
               owbm_pkg::OP_WRITE: begin
                  shifter = w.write_byte;
                  load_write_low();
               end
               default: begin
                  shifter = '0;
                  load_phase(owbm_pkg::PH_RD_LOW, timing_type'(owbm_pkg::READ_LOW_US));
               end
            endcase
         end
      end
      if (bus_phase != owbm_pkg::PH_IDLE) begin
         r.drive_low = (bus_phase == owbm_pkg::PH_RST_LOW) ||
                       (bus_phase == owbm_pkg::PH_WR_LOW) ||
                       (bus_phase == owbm_pkg::PH_RD_LOW);
         slot_timer = slot_timer - 1'b1;
         if (slot_timer == '0) begin
            last_bit = (bit_pos == 3'(owbm_pkg::BITS_PER_BYTE - 1));
            case (bus_phase)
               owbm_pkg::PH_RST_LOW: load_phase(owbm_pkg::PH_RST_WAIT,
                                                timing[owbm_pkg::CSR_PRES_WAIT]);
               owbm_pkg::PH_RST_WAIT: begin
                  presence_flag = !w.line_level;   // low line = device present
                  load_phase(owbm_pkg::PH_RST_TAIL, timing[owbm_pkg::CSR_RESET_TAIL]);
               end
               owbm_pkg::PH_RST_TAIL: begin
                  bus_phase  = owbm_pkg::PH_IDLE;
                  r.done_res = 1'b1;
               end
               owbm_pkg::PH_WR_LOW: load_phase(owbm_pkg::PH_WR_HIGH,
                                               shifter[bit_pos]
                                               ? timing[owbm_pkg::CSR_W1_HIGH]
                                               : timing[owbm_pkg::CSR_W0_HIGH]);
               owbm_pkg::PH_WR_HIGH: begin
                  if (last_bit) begin
                     bus_phase  = owbm_pkg::PH_IDLE;
                     r.done_res = 1'b1;
                  end else begin
                     bit_pos = bit_pos + 1'b1;
                     load_write_low();
                  end
               end
               owbm_pkg::PH_RD_LOW: load_phase(owbm_pkg::PH_RD_WAIT,
                                               timing[owbm_pkg::CSR_RD_SAMPLE]);
               owbm_pkg::PH_RD_WAIT: begin
                  if (w.line_level) begin
                     shifter[bit_pos] = 1'b1;
                  end
                  load_phase(owbm_pkg::PH_RD_TAIL, timing_type'(owbm_pkg::READ_TAIL_US));
               end
               owbm_pkg::PH_RD_TAIL: begin
                  if (last_bit) begin
                     last_read  = shifter;
                     bus_phase  = owbm_pkg::PH_IDLE;
                     r.done_res = 1'b1;
                  end else begin
                     bit_pos = bit_pos + 1'b1;
                     load_phase(owbm_pkg::PH_RD_LOW, timing_type'(owbm_pkg::READ_LOW_US));
                  end
               end
               default: bus_phase = owbm_pkg::PH_IDLE;
            endcase
         end
      end
      r.busy_res  = (bus_phase != owbm_pkg::PH_IDLE);
      r.presence  = presence_flag;
      r.read_byte = last_read;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offer one word after a random gap; once taken, step the model and queue
   // either the scripted word or the predicted one.
   task automatic send_word(input owbm_pkg::req_word_type w, input logic fixed,
                            input owbm_pkg::rsp_word_type want);
      int                     gap;
      owbm_pkg::rsp_word_type predicted;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predicted = bus_microsecond(w);
      awaited_responses.push_back(fixed ? want : predicted);
   endtask

   // tick the running command out to its done word
   task automatic run_out(input line_plan_type plan);
      owbm_pkg::req_word_type w;
      while (plan != LINE_NONE && bus_phase != owbm_pkg::PH_IDLE) begin
         w.operation  = owbm_pkg::OP_TICK;
         w.write_byte = 8'($urandom);
         case (plan)
            LINE_LOW:  w.line_level = 1'b0;
            LINE_HIGH: w.line_level = 1'b1;
            default:   w.line_level = 1'($urandom);
         endcase
         send_word(w, 1'b0, QUIET);
      end
   endtask

   // drop valid and let every response come home; a command may still be running
   task automatic settle_bus();
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
   endtask

   // write all timing registers with values from lo..hi; pipe must be empty
   task automatic program_timing(input int lo, input int hi);
      timing_type    v;
      csr_index_type idx;
      for (int i = 0; i < NUM_TIMINGS; i++) begin
         idx          = csr_index_type'(i);
         v            = timing_type'($urandom_range(lo, hi));
         timing[idx]  = v;
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_data     <= v;
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [1:0] pick_command();
      case ($urandom_range(0, 2))
         0:       return owbm_pkg::OP_RESET;
         1:       return owbm_pkg::OP_WRITE;
         default: return owbm_pkg::OP_READ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      owbm_pkg::req_word_type w;
      timing[owbm_pkg::CSR_RESET_LOW]  = owbm_pkg::CFG_DEFAULTS.reset_low_us;
      timing[owbm_pkg::CSR_PRES_WAIT]  = owbm_pkg::CFG_DEFAULTS.presence_wait_us;
      timing[owbm_pkg::CSR_RESET_TAIL] = owbm_pkg::CFG_DEFAULTS.reset_tail_us;
      timing[owbm_pkg::CSR_W1_LOW]     = owbm_pkg::CFG_DEFAULTS.write_one_low_us;
      timing[owbm_pkg::CSR_W1_HIGH]    = owbm_pkg::CFG_DEFAULTS.write_one_high_us;
      timing[owbm_pkg::CSR_W0_LOW]     = owbm_pkg::CFG_DEFAULTS.write_zero_low_us;
      timing[owbm_pkg::CSR_W0_HIGH]    = owbm_pkg::CFG_DEFAULTS.write_zero_high_us;
      timing[owbm_pkg::CSR_RD_SAMPLE]  = owbm_pkg::CFG_DEFAULTS.read_sample_us;
      bus_phase     = owbm_pkg::PH_IDLE;
      slot_timer    = '0;
      bit_pos       = '0;
      shifter       = '0;
      presence_flag = 1'b0;
      last_read     = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // scripted opening at short fixed timings
      program_timing(SCRIPT_TIMING, SCRIPT_TIMING);
      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         w.operation  = SCRIPT[r].operation;
         w.write_byte = SCRIPT[r].write_byte;
         w.line_level = SCRIPT[r].line_level;
         send_word(w, SCRIPT[r].fixed, SCRIPT[r].want);
         run_out(SCRIPT[r].tail_line);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_bus();
         program_timing(TIMING_LO[p], TIMING_HI[p]);
         send_gap_max = SEND_GAP[p];
         recv_gap_max = RECV_GAP[p];
         if (p == HOLD_PHASE) begin
            long_hold_armed = 1'b1;
         end
         // commands start from idle; now and then one lands mid-run
         for (int n = 0; n < PHASE_WORDS; n++) begin
            w.write_byte = 8'($urandom);
            w.line_level = 1'($urandom);
            if (bus_phase == owbm_pkg::PH_IDLE) begin
               w.operation = ($urandom_range(0, 3) == 0) ? owbm_pkg::OP_TICK
                                                         : pick_command();
            end else begin
               w.operation = ($urandom_range(0, 15) == 0) ? pick_command()
                                                          : owbm_pkg::OP_TICK;
            end
            send_word(w, 1'b0, QUIET);
         end
      end

      settle_bus();
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0 && awaited_responses.size() == 0) begin
         $display("tb_one_wire_bus_master OK");
      end else begin
         $display("tb_one_wire_bus_master NOT OK");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Receiver side: random stall per word, one long hold-off when armed
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   initial begin : response_check
      int                     n;
      owbm_pkg::rsp_word_type due;
      wait (!reset);
      forever begin
         n = $urandom_range(0, recv_gap_max);
         if (long_hold_armed) begin
            n               = LONG_HOLD;
            long_hold_armed = 1'b0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (awaited_responses.size() == 0) begin
            $error("response word with nothing expected");
            failures++;
         end else begin
            due = awaited_responses.pop_front();
            check_field("drive_low", 8'(due.drive_low), 8'(rsp_word.drive_low));
            check_field("busy_res",  8'(due.busy_res),  8'(rsp_word.busy_res));
            check_field("done_res",  8'(due.done_res),  8'(rsp_word.done_res));
            check_field("presence",  8'(due.presence),  8'(rsp_word.presence));
            check_field("read_byte", due.read_byte,     rsp_word.read_byte);
            check_field("rejected",  8'(due.rejected),  8'(rsp_word.rejected));
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_one_wire_bus_master NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
